// ----- rtl/srt_pkg.sv -----
// Shared types and constants for the service registry table.
// Operation and status codes, entry layout and the store write-control struct.
// No dependencies.
package srt_pkg;

  localparam int KEY_W     = 16;
  localparam int INST_W    = 16;
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 8;
  localparam int PAYLOAD_W = INST_W + ADDR_W + PORT_W;

  // Payload layout: instance on top, then address, then port
  localparam int PL_PORT_LO = 0;
  localparam int PL_ADDR_LO = PORT_W;
  localparam int PL_INST_LO = PORT_W + ADDR_W;

  // Operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Miss and wildcard values
  localparam logic [INST_W-1:0] WILDCARD_INSTANCE = 16'hFFFF;
  localparam logic [ADDR_W-1:0] MISS_ADDRESS      = 32'h0000_FFFF;
  localparam logic [PORT_W-1:0] MISS_PORT         = 8'hFF;

  // Write controls for the entry store
  typedef struct packed {
    logic we_valid;
    logic we_entry;
    logic valid_bit;
  } store_wr_t;

  // Scan outcome flags
  typedef struct packed {
    logic hit;
    logic free;
  } match_t;

endpackage

// ----- rtl/service_registry_table_core.sv -----
// Service registry table: one request is scanned over all entries, one entry a cycle.
// A new request is taken only while idle: the single key comparator walks the store,
// and done pulses once the scan, drain and finish steps are through.
// Reset: synchronous; a clearing pass over all entries then zeroes the valid
// bits while busy stays high. The receiver cannot stall: done marks a one-cycle result.
module service_registry_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [srt_pkg::KEY_W-1:0]    service_key,
  input  logic [srt_pkg::INST_W-1:0]   instance_key,
  input  logic [srt_pkg::ADDR_W-1:0]   address_v4,
  input  logic [srt_pkg::PORT_W-1:0]   port_value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [srt_pkg::KEY_W-1:0]    out_service,
  output logic [srt_pkg::INST_W-1:0]   out_instance,
  output logic [srt_pkg::ADDR_W-1:0]   out_address,
  output logic [srt_pkg::PORT_W-1:0]   out_port
);
  import srt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]           state;
  logic [IDX_W-1:0]     scan_cnt;
  logic                 cmp_valid;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 accept;

  logic [1:0]           req_mode;
  logic [KEY_W-1:0]     req_svc;
  logic [INST_W-1:0]    req_inst;
  logic [ADDR_W-1:0]    req_addr;
  logic [PORT_W-1:0]    req_port;

  logic                 rd_valid;
  logic [KEY_W-1:0]     rd_key;
  logic [PAYLOAD_W-1:0] rd_payload;

  match_t               mres;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [PAYLOAD_W-1:0] hit_payload;

  store_wr_t            wr_ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAYLOAD_W-1:0] wr_payload;

  logic [1:0]           status_next;
  logic [INST_W-1:0]    instance_next;
  logic [ADDR_W-1:0]    address_next;
  logic [PORT_W-1:0]    port_next;
  logic                 inst_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  srt_store #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk        (clk),
    .rd_addr    (scan_cnt),
    .rd_valid   (rd_valid),
    .rd_key     (rd_key),
    .rd_payload (rd_payload),
    .wr_addr    (wr_addr),
    .wr_ctl     (wr_ctl),
    .wr_key     (req_svc),
    .wr_payload (wr_payload)
  );

  srt_match #(
    .IDX_W (IDX_W)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .clear       (accept),
    .cmp_valid   (cmp_valid),
    .cmp_idx     (cmp_idx),
    .req_key     (req_svc),
    .rd_valid    (rd_valid),
    .rd_key      (rd_key),
    .rd_payload  (rd_payload),
    .result      (mres),
    .hit_idx     (hit_idx),
    .free_idx    (free_idx),
    .hit_payload (hit_payload)
  );

  // Sequencer: clearing pass, scan, drain of the read pipe, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_cnt  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == S_SCAN);
      case (state)
        S_CLEAR: begin
          if (scan_cnt == LAST_IDX) begin
            scan_cnt <= '0;
            state    <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          scan_cnt <= '0;
          state    <= S_IDLE;
        end
        default: begin
          scan_cnt <= '0;
          state    <= S_CLEAR;
        end
      endcase
    end
  end

  // Track the index of the entry whose read data arrives next cycle
  always_ff @(posedge clk) begin
    cmp_idx <= scan_cnt;
  end

  // Latch the request on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_svc  <= service_key;
      req_inst <= instance_key;
      req_addr <= address_v4;
      req_port <= port_value;
    end
  end

  assign wr_payload = {req_inst, req_addr, req_port};
  assign inst_ok    = (req_inst == WILDCARD_INSTANCE) ||
                      (hit_payload[PL_INST_LO +: INST_W] == req_inst);

  // Store writes: clear during the pass, insert or remove on finish
  always_comb begin
    wr_ctl  = '0;
    wr_addr = scan_cnt;
    if (state == S_CLEAR) begin
      wr_ctl.we_valid = 1'b1;
    end else if (state == S_FINISH) begin
      if (req_mode == MODE_INSERT && !mres.hit && mres.free) begin
        wr_addr          = free_idx;
        wr_ctl.we_valid  = 1'b1;
        wr_ctl.we_entry  = 1'b1;
        wr_ctl.valid_bit = 1'b1;
      end else if (req_mode == MODE_REMOVE && mres.hit) begin
        wr_addr         = hit_idx;
        wr_ctl.we_valid = 1'b1;
      end
    end
  end

  // Form the result
  always_comb begin
    status_next   = ST_NOT_FOUND;
    instance_next = '0;
    address_next  = '0;
    port_next     = '0;
    case (req_mode)
      MODE_INSERT: begin
        if (mres.hit) begin
          status_next = ST_DUPLICATE;
        end else if (mres.free) begin
          status_next = ST_OK;
        end else begin
          status_next = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        status_next = mres.hit ? ST_OK : ST_NOT_FOUND;
      end
      MODE_SEARCH: begin
        if (mres.hit && inst_ok) begin
          status_next   = ST_OK;
          instance_next = req_inst;
          address_next  = hit_payload[PL_ADDR_LO +: ADDR_W];
          port_next     = hit_payload[PL_PORT_LO +: PORT_W];
        end else begin
          status_next   = ST_NOT_FOUND;
          instance_next = WILDCARD_INSTANCE;
          address_next  = MISS_ADDRESS;
          port_next     = MISS_PORT;
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      status       <= status_next;
      out_service  <= req_svc;
      out_instance <= instance_next;
      out_address  <= address_next;
      out_port     <= port_next;
    end
  end

  // A result only appears once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  // The result strobe is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // An accepted item keeps the block busy and starts a scan at the first entry
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && state == S_SCAN && scan_cnt == '0))
    else $error("accepted item did not start a scan");

  // A scan runs on into the drain step only
  a_scan_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SCAN || state == S_DRAIN))
    else $error("scan left early");

  // Stores happen only in the clearing pass or on finish
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_ctl.we_valid |-> (state == S_CLEAR || state == S_FINISH))
    else $error("store write outside clear or finish");

endmodule

// ----- rtl/srt_store.sv -----
// Entry store: valid bits, keys and payloads in three simple dual-port memories.
// One write and one registered read per cycle. Depends on srt_pkg.
module srt_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                           clk,
  input  logic [IDX_W-1:0]               rd_addr,
  output logic                           rd_valid,
  output logic [srt_pkg::KEY_W-1:0]      rd_key,
  output logic [srt_pkg::PAYLOAD_W-1:0]  rd_payload,
  input  logic [IDX_W-1:0]               wr_addr,
  input  srt_pkg::store_wr_t             wr_ctl,
  input  logic [srt_pkg::KEY_W-1:0]      wr_key,
  input  logic [srt_pkg::PAYLOAD_W-1:0]  wr_payload
);
  import srt_pkg::*;

  logic                 valid_mem   [DEPTH];
  logic [KEY_W-1:0]     key_mem     [DEPTH];
  logic [PAYLOAD_W-1:0] payload_mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_ctl.we_valid) begin
      valid_mem[wr_addr] <= wr_ctl.valid_bit;
    end
    if (wr_ctl.we_entry) begin
      key_mem[wr_addr]     <= wr_key;
      payload_mem[wr_addr] <= wr_payload;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_valid   <= valid_mem[rd_addr];
    rd_key     <= key_mem[rd_addr];
    rd_payload <= payload_mem[rd_addr];
  end

endmodule

// ----- rtl/srt_match.sv -----
// Shared key comparator: checks one stored entry per cycle against the request key
// and keeps the first matching slot and the first free slot. Depends on srt_pkg.
module srt_match #(
  parameter int IDX_W = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           cmp_valid,
  input  logic [IDX_W-1:0]               cmp_idx,
  input  logic [srt_pkg::KEY_W-1:0]      req_key,
  input  logic                           rd_valid,
  input  logic [srt_pkg::KEY_W-1:0]      rd_key,
  input  logic [srt_pkg::PAYLOAD_W-1:0]  rd_payload,
  output srt_pkg::match_t                result,
  output logic [IDX_W-1:0]               hit_idx,
  output logic [IDX_W-1:0]               free_idx,
  output logic [srt_pkg::PAYLOAD_W-1:0]  hit_payload
);
  import srt_pkg::*;

  logic key_eq;

  assign key_eq = (rd_key == req_key);

  // Track flags; drop them at the start of each scan
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      result <= '0;
    end else if (cmp_valid) begin
      if (!result.hit && rd_valid && key_eq) begin
        result.hit <= 1'b1;
      end
      if (!result.free && !rd_valid) begin
        result.free <= 1'b1;
      end
    end
  end

  // Hold the slot and payload of the first hit and the first free slot
  always_ff @(posedge clk) begin
    if (cmp_valid && !result.hit && rd_valid && key_eq) begin
      hit_idx     <= cmp_idx;
      hit_payload <= rd_payload;
    end
    if (cmp_valid && !result.free && !rd_valid) begin
      free_idx <= cmp_idx;
    end
  end

endmodule
